FILE: rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants of the cursor array list
// Command codes, controller states, datapath operations and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    // default geometry
    localparam int DEFAULT_CAPACITY   = 8;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int KIND_W    = 4;
    localparam int IN_DATA_W = 32;
    localparam int POS_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int ITEM_W    = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // command codes carried in s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 4'd0,
        KIND_REMOVE  = 4'd1,
        KIND_REPLACE = 4'd2,
        KIND_CLEAR   = 4'd3,
        KIND_START   = 4'd4,
        KIND_END     = 4'd5,
        KIND_NEXT    = 4'd6,
        KIND_PRIOR   = 4'd7,
        KIND_MOVE    = 4'd8,
        KIND_FIND    = 4'd9
    } kind_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOP,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_FIN,
        ST_REM_FIN,
        ST_REP_WR,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SWP_RD_A,
        ST_SWP_RD_B,
        ST_SWP_WR_A,
        ST_SWP_WR_B,
        ST_ITEM_RD,
        ST_ITEM_OUT
    } ctl_state_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_SETUP,
        DP_RD_SHIFT,
        DP_WR_SHIFT,
        DP_INS_FIN,
        DP_REM_FIN,
        DP_REP_WR,
        DP_FIND_RD,
        DP_FIND_CMP,
        DP_SWP_RD_A,
        DP_SWP_RD_B,
        DP_SWP_WR_A,
        DP_SWP_WR_B,
        DP_ITEM_RD,
        DP_LOAD
    } dp_op_t;

    // status from datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cmd_ok;
        logic              loop_more;
        logic              match;
        logic              out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/cursor_array_list_core.sv
// ----------------------------------------------------------------------------
// cursor_array_list_core: bounded ordered list of signed words with a cursor
// Insert, remove, replace, clear, cursor moves, swap and linear search.
// ----------------------------------------------------------------------------
// Sequence: each accepted command is decoded; cursor moves, clear and rejected
// commands go on to the cursor entry read; replace writes one entry, move swaps two,
// insert and remove shift entries one at a time, find compares entries until a hit.
// Throughput: one command at a time; the next is taken only after the result
// loads, the shift and search loops paced by the single entry read port.
// Reset: synchronous active low; empties the list and invalidates the cursor.
`default_nettype none

module cursor_array_list_core
    import cal_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // data[31:0], position[34:32], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind[3:0]
    input  wire logic [KIND_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // found[0], applied[1], is_empty[2], is_full[3], count[7:4],
    // cursor_valid[8], cursor_pos[11:9], cursor_item[43:12], zero fill
    output logic [M_TDATA_W-1:0]      m_tdata
);

    dp_op_t     op;
    dp_status_t status;

    // command sequencer
    cal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    // storage, list state and result register
    cal_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl: command sequencer
// Walks each command through decode, entry shifting, search, replace write or swap, the
// cursor entry read and the result load, one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ctrl
    import cal_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    ctl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (status.kind)
                    KIND_INSERT, KIND_REMOVE:
                        state_next = status.cmd_ok ? ST_LOOP : ST_ITEM_RD;
                    KIND_FIND:    state_next = ST_LOOP;
                    KIND_REPLACE: state_next = status.cmd_ok ? ST_REP_WR : ST_ITEM_RD;
                    KIND_MOVE:    state_next = status.cmd_ok ? ST_SWP_RD_A : ST_ITEM_RD;
                    default:      state_next = ST_ITEM_RD;
                endcase
            end
            ST_LOOP: begin
                if (status.loop_more) begin
                    state_next = (status.kind == KIND_FIND) ? ST_FIND_RD : ST_SH_RD;
                end else if (status.kind == KIND_INSERT) begin
                    state_next = ST_INS_FIN;
                end else if (status.kind == KIND_REMOVE) begin
                    state_next = ST_REM_FIN;
                end else begin
                    state_next = ST_ITEM_RD;
                end
            end
            ST_SH_RD:    state_next = ST_SH_WR;
            ST_SH_WR:    state_next = ST_LOOP;
            ST_INS_FIN:  state_next = ST_ITEM_RD;
            ST_REM_FIN:  state_next = ST_ITEM_RD;
            ST_REP_WR:   state_next = ST_ITEM_RD;
            ST_FIND_RD:  state_next = ST_FIND_CMP;
            ST_FIND_CMP: state_next = status.match ? ST_ITEM_RD : ST_LOOP;
            ST_SWP_RD_A: state_next = ST_SWP_RD_B;
            ST_SWP_RD_B: state_next = ST_SWP_WR_A;
            ST_SWP_WR_A: state_next = ST_SWP_WR_B;
            ST_SWP_WR_B: state_next = ST_ITEM_RD;
            ST_ITEM_RD:  state_next = ST_ITEM_OUT;
            ST_ITEM_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs; no word is taken while reset is held
    always_comb begin
        s_tready = 1'b0;
        op       = DP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) op = DP_CAPTURE;
            end
            ST_DECODE:   op = DP_SETUP;
            ST_SH_RD:    op = DP_RD_SHIFT;
            ST_SH_WR:    op = DP_WR_SHIFT;
            ST_INS_FIN:  op = DP_INS_FIN;
            ST_REM_FIN:  op = DP_REM_FIN;
            ST_REP_WR:   op = DP_REP_WR;
            ST_FIND_RD:  op = DP_FIND_RD;
            ST_FIND_CMP: op = DP_FIND_CMP;
            ST_SWP_RD_A: op = DP_SWP_RD_A;
            ST_SWP_RD_B: op = DP_SWP_RD_B;
            ST_SWP_WR_A: op = DP_SWP_WR_A;
            ST_SWP_WR_B: op = DP_SWP_WR_B;
            ST_ITEM_RD:  op = DP_ITEM_RD;
            ST_ITEM_OUT: op = DP_LOAD;
            default:     op = DP_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cal_datapath.sv
// ----------------------------------------------------------------------------
// cal_datapath: entry memory, list and cursor registers, result register
// Entry memory has one write port and one registered read port; every
// operation from the controller does at most one access of each kind.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_datapath
    import cal_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_op_t               op,
    output dp_status_t                status,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [KIND_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // entry memory
    logic [DATA_WIDTH-1:0] entry_mem_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // control state
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic          cur_ok_reg, cur_ok_next;
    logic          m_tvalid_reg;

    // command and working registers
    logic [KIND_W-1:0]     kind_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CW-1:0]         idx_reg;
    logic [DATA_WIDTH-1:0] tmp_reg;
    logic                  found_reg;
    logic                  applied_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    // derived values
    logic [63:0]           in_wide;
    logic signed [63:0]    item_wide;
    logic [CW-1:0]         cur_w;
    logic [CW-1:0]         at_idx;
    logic [CW-1:0]         idx_dec;
    logic [CW:0]           idx_inc;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         count_pw;
    logic [IW-1:0]         pos_idx;
    logic [CW-1:0]         count_dec;
    logic                  cur_in;
    logic                  cmd_ok;
    logic                  loop_more;
    logic                  match;
    logic                  out_free;
    logic [ITEM_W-1:0]     item_out;
    logic [COUNT_W-1:0]    count_out;
    logic [POS_W-1:0]      pos_out;

    // input word sign-extended, then held at the stored width
    assign in_wide   = {{(64 - IN_DATA_W){s_tdata[IN_DATA_W-1]}}, s_tdata[IN_DATA_W-1:0]};
    assign item_wide = 64'($signed(rd_data_reg));

    assign cur_w     = CW'(cur_reg);
    assign at_idx    = cur_ok_reg ? (cur_w + CW'(1)) : '0;
    assign idx_dec   = idx_reg - CW'(1);
    assign idx_inc   = {1'b0, idx_reg} + (CW + 1)'(1);
    assign pos_w     = PW'(pos_reg);
    assign count_pw  = PW'(count_reg);
    assign pos_idx   = pos_w[IW-1:0];
    assign count_dec = count_reg - CW'(1);
    assign cur_in    = cur_ok_reg && (cur_w < count_reg);
    assign match     = (rd_data_reg == value_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // whether the held command may be carried out
    always_comb begin
        case (kind_reg)
            KIND_INSERT:  cmd_ok = (count_reg < CW'(CAPACITY));
            KIND_REMOVE:  cmd_ok = cur_in;
            KIND_REPLACE: cmd_ok = cur_in;
            KIND_CLEAR:   cmd_ok = 1'b1;
            KIND_START:   cmd_ok = (count_reg != '0);
            KIND_END:     cmd_ok = (count_reg != '0);
            KIND_NEXT:    cmd_ok = cur_ok_reg && ((cur_w + CW'(1)) < count_reg);
            KIND_PRIOR:   cmd_ok = cur_ok_reg && (cur_reg != '0);
            KIND_MOVE:    cmd_ok = cur_in && (pos_w < count_pw);
            KIND_FIND:    cmd_ok = 1'b1;
            default:      cmd_ok = 1'b0;
        endcase
    end

    // loop test: insert walks down to the slot, remove and find walk up
    always_comb begin
        case (kind_reg)
            KIND_INSERT: loop_more = (idx_reg > at_idx);
            KIND_REMOVE: loop_more = (idx_inc < {1'b0, count_reg});
            default:     loop_more = (idx_reg < count_reg);
        endcase
    end

    assign status.kind      = kind_reg;
    assign status.cmd_ok    = cmd_ok;
    assign status.loop_more = loop_more;
    assign status.match     = match;
    assign status.out_free  = out_free;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = value_reg;
        case (op)
            DP_RD_SHIFT: begin
                rd_en   = 1'b1;
                rd_addr = (kind_reg == KIND_INSERT) ? idx_dec[IW-1:0] : idx_inc[IW-1:0];
            end
            DP_WR_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IW-1:0];
                wr_data = rd_data_reg;
            end
            DP_INS_FIN: begin
                wr_en   = 1'b1;
                wr_addr = at_idx[IW-1:0];
            end
            DP_REP_WR: begin
                wr_en   = 1'b1;
            end
            DP_FIND_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IW-1:0];
            end
            DP_SWP_RD_A: begin
                rd_en   = 1'b1;
            end
            DP_SWP_RD_B: begin
                rd_en   = 1'b1;
                rd_addr = pos_idx;
            end
            DP_SWP_WR_A: begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
            end
            DP_SWP_WR_B: begin
                wr_en   = 1'b1;
                wr_addr = pos_idx;
                wr_data = tmp_reg;
            end
            DP_ITEM_RD: begin
                rd_en   = 1'b1;
            end
            default: begin
                rd_en   = 1'b0;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) entry_mem_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= entry_mem_reg[rd_addr];
    end

    // next count and cursor
    always_comb begin
        count_next  = count_reg;
        cur_next    = cur_reg;
        cur_ok_next = cur_ok_reg;
        case (op)
            DP_SETUP: begin
                case (kind_reg)
                    KIND_CLEAR: begin
                        count_next  = '0;
                        cur_next    = '0;
                        cur_ok_next = 1'b0;
                    end
                    KIND_START: begin
                        if (cmd_ok) begin
                            cur_next    = '0;
                            cur_ok_next = 1'b1;
                        end
                    end
                    KIND_END: begin
                        if (cmd_ok) begin
                            cur_next    = count_dec[IW-1:0];
                            cur_ok_next = 1'b1;
                        end
                    end
                    KIND_NEXT: begin
                        if (cmd_ok) cur_next = cur_reg + IW'(1);
                    end
                    KIND_PRIOR: begin
                        if (cmd_ok) cur_next = cur_reg - IW'(1);
                    end
                    default: begin
                        cur_next = cur_reg;
                    end
                endcase
            end
            DP_INS_FIN: begin
                count_next  = count_reg + CW'(1);
                cur_next    = at_idx[IW-1:0];
                cur_ok_next = 1'b1;
            end
            DP_REM_FIN: begin
                count_next = count_dec;
                if (count_dec == '0) begin
                    cur_next    = '0;
                    cur_ok_next = 1'b0;
                end else if (cur_w >= count_dec) begin
                    cur_next = '0;
                end
            end
            DP_FIND_CMP: begin
                if (match) begin
                    cur_next    = idx_reg[IW-1:0];
                    cur_ok_next = 1'b1;
                end
            end
            DP_SWP_WR_B: begin
                cur_next = pos_idx;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            cur_reg      <= '0;
            cur_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            cur_ok_reg <= cur_ok_next;
            if (op == DP_LOAD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result fields
    assign item_out  = cur_in ? item_wide[ITEM_W-1:0] : '0;
    assign count_out = COUNT_W'(count_reg);
    assign pos_out   = cur_in ? POS_W'(cur_reg) : '0;

    // command, loop and result registers
    always_ff @(posedge aclk) begin
        case (op)
            DP_CAPTURE: begin
                kind_reg  <= s_tuser;
                value_reg <= in_wide[DATA_WIDTH-1:0];
                pos_reg   <= s_tdata[IN_DATA_W +: POS_W];
            end
            DP_SETUP: begin
                found_reg   <= 1'b0;
                applied_reg <= cmd_ok && (kind_reg != KIND_FIND);
                case (kind_reg)
                    KIND_INSERT: idx_reg <= count_reg;
                    KIND_REMOVE: idx_reg <= cur_w;
                    default:     idx_reg <= '0;
                endcase
            end
            DP_WR_SHIFT: begin
                idx_reg <= (kind_reg == KIND_INSERT) ? idx_dec : idx_inc[CW-1:0];
            end
            DP_FIND_CMP: begin
                if (match) begin
                    found_reg   <= 1'b1;
                    applied_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_inc[CW-1:0];
                end
            end
            DP_SWP_RD_B: begin
                tmp_reg <= rd_data_reg;
            end
            DP_LOAD: begin
                if (out_free) begin
                    m_tdata_reg <= {4'd0, item_out, pos_out, cur_in, count_out,
                                    (count_reg == CW'(CAPACITY)), (count_reg == '0),
                                    applied_reg, found_reg};
                end
            end
            default: begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
